// File: rtl/core/bscr_pkg.sv
// Shared types and constants for the box screen rectangle block.
`timescale 1ns / 1ps
package bscr_pkg;

    localparam int FIELD_W   = 21;
    localparam int UNIT_FRAC = 19;
    localparam int PIX_FRAC  = 8;
    localparam int D_W       = 24;
    localparam int PROD_W    = 45;
    localparam int SUM_W     = 47;
    localparam int C_W       = 28;
    localparam int DIV_W     = 64;
    localparam int QUO_W     = 22;
    localparam int PIX_W     = 25;
    localparam int PX_W      = 21;
    localparam int DIM_W     = 13;
    localparam int TAN_W     = 24;
    localparam int TA_W      = 32;

    typedef enum logic [2:0] {
        REG_POS,
        REG_RIGHT,
        REG_UP,
        REG_DIR,
        REG_TAN,
        REG_ASPECT,
        REG_WIDTH,
        REG_HEIGHT
    } cfg_index_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } corner_ctl_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             sat;
    } div_lane_t;

endpackage

// File: rtl/core/bscr_div_cell.sv
// One restoring divider cell: settles one quotient bit for the x and y lanes.
`timescale 1ns / 1ps
module bscr_div_cell
    import bscr_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  corner_ctl_t ctl_in,
    input  div_lane_t   x_in,
    input  div_lane_t   y_in,
    output corner_ctl_t ctl_out,
    output div_lane_t   x_out,
    output div_lane_t   y_out
);

    function automatic div_lane_t div_step(div_lane_t l);
        div_lane_t r;
        r = l;
        if (!l.sat && ((l.rem >> BIT) >= l.den))
        begin
            r.rem      = l.rem - (l.den << BIT);
            r.quo[BIT] = 1'b1;
        end
        return r;
    endfunction

    corner_ctl_t ctl_reg;
    div_lane_t   x_reg;
    div_lane_t   y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= div_step(x_in);
            y_reg <= div_step(y_in);
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;

endmodule

// File: rtl/core/bscr_div_chain.sv
// Row of divider cells, one quotient bit per cell, most significant first.
`timescale 1ns / 1ps
module bscr_div_chain
    import bscr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  corner_ctl_t ctl_in,
    input  div_lane_t   x_in,
    input  div_lane_t   y_in,
    output corner_ctl_t ctl_out,
    output div_lane_t   x_out,
    output div_lane_t   y_out
);

    corner_ctl_t ctl_w [QUO_W+1];
    div_lane_t   x_w   [QUO_W+1];
    div_lane_t   y_w   [QUO_W+1];

    assign ctl_w[0] = ctl_in;
    assign x_w[0]   = x_in;
    assign y_w[0]   = y_in;

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        bscr_div_cell #(
            .BIT (QUO_W - 1 - i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .ctl_in  (ctl_w[i]),
            .x_in    (x_w[i]),
            .y_in    (y_w[i]),
            .ctl_out (ctl_w[i+1]),
            .x_out   (x_w[i+1]),
            .y_out   (y_w[i+1])
        );
    end

    assign ctl_out = ctl_w[QUO_W];
    assign x_out   = x_w[QUO_W];
    assign y_out   = y_w[QUO_W];

endmodule

// File: rtl/core/box_screen_clip_rect.sv
// Top level: screen rectangle covering a perspective-projected box.
//
// Usage:
//   Write camera position, basis vectors, field of view, aspect and window
//   size through cfg_we / cfg_index / cfg_data while no box is in flight.
//   Send one box per request on s_tvalid / s_tready / s_tdata; each box
//   yields one rectangle on m_tvalid / m_tready / m_tdata.
// Throughput: one corner per cycle unless stalled, through the shared
//   dot-product multipliers and a 22-cell divider row (one quotient bit
//   per cell) for the x and y projections; boxes follow back to back.
// Path: issue, corner offsets, products, camera coordinates, numerators
//   and divisors, divider lanes, 22 divider cells, clamp, then the min/max
//   accumulation over eight corners into the output register.
// Reset: config registers return to their defaults, all stages empty.
// Stall: a finished result waits in the output register; the pipeline and
//   the input keep running until the next finished rectangle would need
//   that register, then everything holds until m_tready.
`timescale 1ns / 1ps
module box_screen_clip_rect
    import bscr_pkg::*;
#(
    parameter int COORD_WIDTH = 21
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [2:0]                               cfg_index,
    input  logic [62:0]                              cfg_data,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // center_x, center_y, center_z, extent_x, extent_y, extent_z, zero pad
    input  logic [((6*COORD_WIDTH-3+7)/8)*8-1:0]     s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // clip_x, clip_y, rect_width, rect_height, zero pad
    output logic [55:0]                              m_tdata
);

    localparam int CW = COORD_WIDTH;

    logic [62:0]      pos_reg, right_reg, up_reg, dir_reg;
    logic [TAN_W-1:0] tan_reg, aspect_reg;
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [TA_W-1:0]  ta_reg;
    logic [2*TAN_W-1:0] ta_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            right_reg  <= '0;
            up_reg     <= '0;
            dir_reg    <= '0;
            tan_reg    <= TAN_W'(65536);
            aspect_reg <= TAN_W'(87381);
            width_reg  <= DIM_W'(1024);
            height_reg <= DIM_W'(768);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_POS:    pos_reg    <= cfg_data;
                REG_RIGHT:  right_reg  <= cfg_data;
                REG_UP:     up_reg     <= cfg_data;
                REG_DIR:    dir_reg    <= cfg_data;
                REG_TAN:    tan_reg    <= cfg_data[TAN_W-1:0];
                REG_ASPECT: aspect_reg <= cfg_data[TAN_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    assign ta_prod = (2*TAN_W)'(tan_reg) * (2*TAN_W)'(aspect_reg);

    always_ff @(posedge clk)
    begin
        ta_reg <= ta_prod[2*TAN_W-1:16];
    end

    // stall only when a finished rectangle meets a full output register
    logic        adv;
    corner_ctl_t st5_ctl_reg;
    logic        out_valid_reg;

    assign adv = !(st5_ctl_reg.valid && st5_ctl_reg.last && out_valid_reg && !m_tready);

    // input item and corner issue
    logic                      busy_reg;
    logic [2:0]                cnt_reg;
    logic signed [FIELD_W-1:0] ctr_reg [3];
    logic [FIELD_W-2:0]        ext_reg [3];
    logic                      accept;

    assign s_tready = adv && (!busy_reg || (cnt_reg == 3'd7));
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (adv)
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int a = 0; a < 3; a++)
            begin
                ctr_reg[a] <= FIELD_W'($signed(s_tdata[a*CW +: CW]));
                ext_reg[a] <= (FIELD_W-1)'(s_tdata[3*CW + a*(CW-1) +: CW-1]);
            end
        end
    end

    // stage 1: corner offsets
    corner_ctl_t           st1_ctl_reg;
    logic signed [D_W-1:0] d_reg [3];
    logic signed [D_W-1:0] d_next [3];

    always_comb
    begin
        logic signed [FIELD_W-1:0] cam;
        logic signed [D_W-1:0]     ext;
        for (int a = 0; a < 3; a++)
        begin
            cam = FIELD_W'($signed(pos_reg[a*FIELD_W +: CW]));
            ext = $signed(D_W'(ext_reg[a]));
            d_next[a] = (D_W'(ctr_reg[a]) <<< 1) + (cnt_reg[a] ? ext : -ext)
                        - (D_W'(cam) <<< 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_ctl_reg <= '0;
        end
        else if (adv)
        begin
            st1_ctl_reg.valid <= busy_reg;
            st1_ctl_reg.first <= (cnt_reg == 3'd0);
            st1_ctl_reg.last  <= (cnt_reg == 3'd7);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_next;
        end
    end

    // stage 2: nine products, rows right, up, direction
    corner_ctl_t              st2_ctl_reg;
    logic signed [PROD_W-1:0] p_reg [3][3];
    logic [62:0]              unit [3];

    assign unit[0] = right_reg;
    assign unit[1] = up_reg;
    assign unit[2] = dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st2_ctl_reg <= '0;
        end
        else if (adv)
        begin
            st2_ctl_reg <= st1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int v = 0; v < 3; v++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    p_reg[v][a] <= PROD_W'(d_reg[a])
                                   * PROD_W'($signed(unit[v][a*FIELD_W +: FIELD_W]));
                end
            end
        end
    end

    // stage 3: camera coordinates
    corner_ctl_t           st3_ctl_reg;
    logic signed [C_W-1:0] c_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st3_ctl_reg <= '0;
        end
        else if (adv)
        begin
            st3_ctl_reg <= st2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [SUM_W-1:0] s;
        if (adv)
        begin
            for (int v = 0; v < 3; v++)
            begin
                s = SUM_W'(p_reg[v][0]) + SUM_W'(p_reg[v][1]) + SUM_W'(p_reg[v][2]);
                c_reg[v] <= C_W'(s >>> UNIT_FRAC);
            end
        end
    end

    // stage 4: numerators and divisors
    corner_ctl_t         st4_ctl_reg;
    logic signed [41:0]  wcx_reg, hcy_reg;
    logic [58:0]         dx_reg;
    logic [50:0]         dy_reg;
    logic                czpos_reg;
    logic [26:0]         czm;

    assign czm = c_reg[2][26:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st4_ctl_reg <= '0;
        end
        else if (adv)
        begin
            st4_ctl_reg <= st3_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wcx_reg   <= 42'($signed({1'b0, width_reg})) * 42'(c_reg[0]);
            hcy_reg   <= 42'($signed({1'b0, height_reg})) * 42'(c_reg[1]);
            dx_reg    <= 59'(czm) * 59'(ta_reg);
            dy_reg    <= 51'(czm) * 51'(tan_reg);
            czpos_reg <= (c_reg[2] > 0);
        end
    end

    // stage 5: divider lanes
    corner_ctl_t st_div_ctl_reg;
    div_lane_t   x_lane_reg, y_lane_reg;

    function automatic div_lane_t make_lane(logic signed [41:0] num,
                                            logic [DIV_W-1:0] den, logic pos);
        div_lane_t         l;
        logic [41:0]       mag;
        logic [DIV_W-1:0]  n;
        mag   = num[41] ? 42'(-num) : 42'(num);
        n     = DIV_W'(mag) << 24;
        l.rem = n;
        l.den = den;
        l.quo = '0;
        l.neg = num[41];
        l.sat = !pos || (den == '0) || ((n >> QUO_W) >= den);
        return l;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_div_ctl_reg <= '0;
        end
        else if (adv)
        begin
            st_div_ctl_reg <= st4_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_lane_reg <= make_lane(wcx_reg, DIV_W'(dx_reg) << 1, czpos_reg);
            y_lane_reg <= make_lane(hcy_reg, DIV_W'(dy_reg) << 1, czpos_reg);
        end
    end

    corner_ctl_t chain_ctl;
    div_lane_t   chain_x, chain_y;

    bscr_div_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .ctl_in  (st_div_ctl_reg),
        .x_in    (x_lane_reg),
        .y_in    (y_lane_reg),
        .ctl_out (chain_ctl),
        .x_out   (chain_x),
        .y_out   (chain_y)
    );

    // window offset and clamp
    logic [PX_W-1:0] px_reg, py_reg;
    logic [PX_W-1:0] wq, hq;

    assign wq = PX_W'(width_reg) << PIX_FRAC;
    assign hq = PX_W'(height_reg) << PIX_FRAC;

    function automatic logic [PX_W-1:0] place(div_lane_t l, logic [DIM_W-1:0] size,
                                              logic [PX_W-1:0] lim);
        logic signed [PIX_W-1:0] mag;
        logic signed [PIX_W-1:0] p;
        mag = l.sat ? $signed(PIX_W'(1) << QUO_W) : $signed(PIX_W'(l.quo));
        p   = (l.neg ? -mag : mag) + $signed(PIX_W'(size) << (PIX_FRAC - 1));
        if (p < 0)
        begin
            return '0;
        end
        else if (p > $signed(PIX_W'(lim)))
        begin
            return lim;
        end
        return PX_W'(p);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st5_ctl_reg <= '0;
        end
        else if (adv)
        begin
            st5_ctl_reg <= chain_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= place(chain_x, width_reg, wq);
            py_reg <= place(chain_y, height_reg, hq);
        end
    end

    // min/max over corners and result
    logic [PX_W-1:0]  left_reg, right_acc_reg, down_reg, top_reg;
    logic [PX_W-1:0]  left_next, right_next, down_next, top_next;
    logic [DIM_W-1:0] clip_x_reg, clip_y_reg, clip_w_reg, clip_h_reg;

    always_comb
    begin
        logic [PX_W-1:0] l0, r0, d0, t0;
        l0 = st5_ctl_reg.first ? wq : left_reg;
        r0 = st5_ctl_reg.first ? '0 : right_acc_reg;
        d0 = st5_ctl_reg.first ? hq : down_reg;
        t0 = st5_ctl_reg.first ? '0 : top_reg;
        left_next  = (px_reg < l0) ? px_reg : l0;
        right_next = (px_reg > r0) ? px_reg : r0;
        down_next  = (py_reg < d0) ? py_reg : d0;
        top_next   = (py_reg > t0) ? py_reg : t0;
    end

    always_ff @(posedge clk)
    begin
        logic [PX_W-1:0] dw, dh;
        if (adv && st5_ctl_reg.valid)
        begin
            left_reg      <= left_next;
            right_acc_reg <= right_next;
            down_reg      <= down_next;
            top_reg       <= top_next;
            if (st5_ctl_reg.last)
            begin
                dw = (right_next > left_next) ? right_next - left_next : '0;
                dh = (top_next > down_next) ? top_next - down_next : '0;
                clip_x_reg <= DIM_W'(left_next >> PIX_FRAC);
                clip_y_reg <= DIM_W'(down_next >> PIX_FRAC);
                clip_w_reg <= DIM_W'(dw >> PIX_FRAC);
                clip_h_reg <= DIM_W'(dh >> PIX_FRAC);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && st5_ctl_reg.valid && st5_ctl_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, clip_h_reg, clip_w_reg, clip_y_reg, clip_x_reg};

    a_no_accept_mid_box: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg != 3'd7) |-> !s_tready)
        else $error("request accepted while corners of a box are still issuing");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(px_reg) && $stable(cnt_reg) && $stable(st5_ctl_reg)))
        else $error("pipeline moved while the output was blocked");

    a_rect_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((14'(clip_x_reg) + 14'(clip_w_reg)) <= 14'(width_reg)))
        else $error("rectangle exceeds window width");

endmodule

// File: sim/tb_box_screen_clip_rect.sv
// Self-checking bench for box_screen_clip_rect: random and directed boxes against a predictor.
`timescale 1ns / 1ps
module tb_box_screen_clip_rect;
    import bscr_pkg::*;

    localparam int  CW        = 21;
    localparam int  SETTLE    = 80;
    localparam longint LIMIT  = 600000;
    localparam longint Q_SAT  = 64'sd1 << 40;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cz;
        logic [CW-2:0]        ex;
        logic [CW-2:0]        ey;
        logic [CW-2:0]        ez;
    } box_t;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } rect_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic [2:0]    cfg_index = '0;
    logic [62:0]   cfg_data = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [127:0]  s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [55:0]   m_tdata;

    logic [62:0]   cam_pos, basis_right, basis_up, basis_dir;
    logic [23:0]   tan_fov, aspect;
    logic [12:0]   win_w, win_h;

    rect_t         pending_rects[$];
    int            errors = 0;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    int            rx_hold = 0;
    longint        cycles = 0;

    box_screen_clip_rect #(.COORD_WIDTH(CW)) dut (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        rect_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[12:0], m_tdata[25:13], m_tdata[38:26], m_tdata[51:39]};
            if (pending_rects.size() == 0)
            begin
                $error("unexpected rectangle %h", got);
                errors++;
            end
            else
            begin
                want = pending_rects.pop_front();
                if (got.x != want.x)
                begin
                    $error("clip_x exp %0d got %0d", want.x, got.x);
                    errors++;
                end
                if (got.y != want.y)
                begin
                    $error("clip_y exp %0d got %0d", want.y, got.y);
                    errors++;
                end
                if (got.w != want.w)
                begin
                    $error("rect_width exp %0d got %0d", want.w, got.w);
                    errors++;
                end
                if (got.h != want.h)
                begin
                    $error("rect_height exp %0d got %0d", want.h, got.h);
                    errors++;
                end
            end
        end
    end

    function automatic longint sext(logic [62:0] v, int idx);
        logic signed [20:0] f;
        f = v[idx*21 +: 21];
        return longint'(f);
    endfunction

    function automatic longint dot_basis(logic [62:0] basis, longint d[3]);
        longint s;
        s = 0;
        for (int a = 0; a < 3; a++)
            s += d[a] * sext(basis, a);
        return s >>> UNIT_FRAC;
    endfunction

    function automatic longint to_pixel(longint num, longint den, logic [12:0] size);
        longint q;
        if (den <= 0)
            q = (num >= 0) ? Q_SAT : -Q_SAT;
        else
            q = num / den;
        return q + (longint'(size) << 7);
    endfunction

    function automatic rect_t project_box(box_t b);
        longint ctr2[3], ext[3], cam2[3], d[3];
        longint ta, wq, hq, lft, rgt, bot, top, px, py, vx, vy, vz;
        rect_t r;
        ta   = longint'((64'(tan_fov) * 64'(aspect)) >> 16);
        wq   = longint'(win_w) << PIX_FRAC;
        hq   = longint'(win_h) << PIX_FRAC;
        lft  = wq;
        rgt  = 0;
        bot  = hq;
        top  = 0;
        ctr2 = '{2 * longint'(b.cx), 2 * longint'(b.cy), 2 * longint'(b.cz)};
        ext  = '{longint'(b.ex), longint'(b.ey), longint'(b.ez)};
        for (int a = 0; a < 3; a++)
            cam2[a] = 2 * sext(cam_pos, a);
        for (int c = 0; c < 8; c++)
        begin
            for (int a = 0; a < 3; a++)
                d[a] = ctr2[a] + (((c >> a) & 1) ? ext[a] : -ext[a]) - cam2[a];
            vx = dot_basis(basis_right, d);
            vy = dot_basis(basis_up, d);
            vz = dot_basis(basis_dir, d);
            if (vz <= 0)
            begin
                px = to_pixel(vx, 0, win_w);
                py = to_pixel(vy, 0, win_h);
            end
            else
            begin
                px = to_pixel(longint'(win_w) * vx * 16777216, 2 * vz * ta, win_w);
                py = to_pixel(longint'(win_h) * vy * 16777216,
                              2 * vz * longint'(tan_fov), win_h);
            end
            if (px < lft) lft = px;
            if (px > rgt) rgt = px;
            if (py > top) top = py;
            if (py < bot) bot = py;
        end
        if (bot < 0) bot = 0;
        if (top > hq) top = hq;
        if (lft < 0) lft = 0;
        if (rgt > wq) rgt = wq;
        r.x = 13'(lft >> PIX_FRAC);
        r.y = 13'(bot >> PIX_FRAC);
        r.w = (rgt > lft) ? 13'((rgt - lft) >> PIX_FRAC) : '0;
        r.h = (top > bot) ? 13'((top - bot) >> PIX_FRAC) : '0;
        return r;
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [62:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_POS:    cam_pos     = val;
            REG_RIGHT:  basis_right = val;
            REG_UP:     basis_up    = val;
            REG_DIR:    basis_dir   = val;
            REG_TAN:    tan_fov     = val[23:0];
            REG_ASPECT: aspect      = val[23:0];
            REG_WIDTH:  win_w       = val[12:0];
            REG_HEIGHT: win_h       = val[12:0];
            default: ;
        endcase
    endtask

    task automatic send_box(box_t b);
        int gap;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, b.ez, b.ey, b.ex, b.cz, b.cy, b.cx};
        do @(posedge clk); while (!s_tready);
        pending_rects.insert(pending_rects.size(), project_box(b));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_rects.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [62:0] pack3(int x, int y, int z);
        return {21'(z), 21'(y), 21'(x)};
    endfunction

    function automatic box_t shaped_box();
        box_t b;
        b.cx = 21'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
        b.cy = 21'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
        b.cz = 21'($signed($urandom_range(0, 1 << 18)) - (1 << 14));
        b.ex = 20'($urandom_range(0, 1 << 14));
        b.ey = 20'($urandom_range(0, 1 << 14));
        b.ez = 20'($urandom_range(0, 1 << 14));
        return b;
    endfunction

    function automatic box_t noise_box();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return box_t'(raw[$bits(box_t)-1:0]);
    endfunction

    task automatic camera_axes();
        int one;
        one = 1 << UNIT_FRAC;
        write_reg(REG_POS, pack3($urandom_range(0, 4096) - 2048,
                                 $urandom_range(0, 4096) - 2048, -($urandom_range(0, 8192))));
        write_reg(REG_RIGHT, pack3($urandom_range(1) ? one : -one, 0, 0));
        write_reg(REG_UP, pack3(0, $urandom_range(1) ? one : -one, 0));
        write_reg(REG_DIR, pack3(0, 0, one));
        write_reg(REG_TAN, 63'($urandom_range(16384, 200000)));
        write_reg(REG_ASPECT, 63'($urandom_range(32768, 150000)));
        write_reg(REG_WIDTH, 63'($urandom_range(1, 4096)));
        write_reg(REG_HEIGHT, 63'($urandom_range(1, 4096)));
    endtask

    task automatic camera_extreme(int pick);
        write_reg(REG_TAN, 63'(pick[0] ? 24'hFFFFFF : 24'd1));
        write_reg(REG_ASPECT, 63'(pick[1] ? 24'hFFFFFF : 24'd1));
        write_reg(REG_WIDTH, 63'(pick[0] ? 13'd4096 : 13'd1));
        write_reg(REG_HEIGHT, 63'(pick[1] ? 13'd1 : 13'd4096));
    endtask

    task automatic test_defaults();
        send_box('0);
        send_box(shaped_box());
        wait_idle();
    endtask

    task automatic test_directed();
        box_t b;
        camera_axes();
        b = '0;
        b.cz = 21'sd25600;
        send_box(b);
        b.ex = '1; b.ey = '1; b.ez = '1;
        send_box(b);
        b.cx = 21'h0FFFFF; b.cy = 21'h0FFFFF; b.cz = 21'h0FFFFF;
        send_box(b);
        b.cx = 21'h100000; b.cy = 21'h100000; b.cz = 21'h100000;
        send_box(b);
        b = '0;
        b.cz = 21'h100000;
        send_box(b);
        b.cz = 21'sd1;
        send_box(b);
        b.cx = 21'sd4000; b.cz = 21'sd2560; b.ex = 20'd1;
        send_box(b);
        for (int i = 0; i < 6; i++)
            send_box(shaped_box());
        wait_idle();
        write_reg(REG_TAN, 63'(24'd0));
        write_reg(REG_WIDTH, 63'(13'd0));
        write_reg(REG_HEIGHT, 63'(13'd0));
        send_box(shaped_box());
        send_box(shaped_box());
        wait_idle();
        for (int p = 0; p < 4; p++)
        begin
            camera_extreme(p);
            send_box(shaped_box());
            send_box(noise_box());
            wait_idle();
        end
        write_reg(REG_POS, {63{1'b1}});
        write_reg(REG_RIGHT, 63'({1'b0, 21'h100000, 21'h0FFFFF}));
        write_reg(REG_UP, {63{1'b1}});
        write_reg(REG_DIR, {21'h100000, 21'h100000, 21'h100000});
        send_box(noise_box());
        send_box(noise_box());
        wait_idle();
    endtask

    task automatic test_random(int tx_pct, int rx_pct, int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                wait_idle();
                if ($urandom_range(4) == 0)
                begin
                    camera_extreme($urandom_range(3));
                    write_reg(REG_POS, 63'({$urandom, $urandom}));
                    write_reg(REG_RIGHT, 63'({$urandom, $urandom}));
                    write_reg(REG_UP, 63'({$urandom, $urandom}));
                    write_reg(REG_DIR, 63'({$urandom, $urandom}));
                end
                else
                    camera_axes();
            end
            send_box(($urandom_range(99) < 80) ? shaped_box() : noise_box());
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        camera_axes();
        rx_hold = 400;
        for (int i = 0; i < 30; i++)
            send_box(shaped_box());
        wait_idle();
        for (int i = 0; i < 5; i++)
            send_box(shaped_box());
        wait_idle();
    endtask

    initial
    begin
        cam_pos     = '0;
        basis_right = '0;
        basis_up    = '0;
        basis_dir   = '0;
        tan_fov     = 24'd65536;
        aspect      = 24'd87381;
        win_w       = 13'd1024;
        win_h       = 13'd768;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_directed();
        test_random(6, 47, 300);
        test_random(47, 6, 300);
        test_random(0, 0, 300);
        test_backpressure();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
